// ----- sv/b2da_pkg.sv -----
`timescale 1ns / 1ps

package b2da_pkg;

  // width of the value field on the input stream
  localparam int unsigned VALUE_BITS = 64;
  // width of one ascii character code on the output stream
  localparam int unsigned CHAR_W = 6;
  // one bcd digit
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // shift-and-add-3 correction
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_OFFSET = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  // controls broadcast to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correct, then shift one bit in from below
    logic shift;   // take the digit of the cell below
  } cell_ctrl_t;

endpackage

// ----- sv/b2da_cell.sv -----
`timescale 1ns / 1ps

module b2da_cell import b2da_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic               bit_i,    // bit from the less significant neighbor
  input  logic [DIGIT_W-1:0] digit_i,  // digit from the less significant neighbor
  output logic               carry_o,  // bit handed to the more significant neighbor
  output logic [DIGIT_W-1:0] digit_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  // correction depends only on the stored digit, so no ripple along the row
  assign adj     = (digit_q >= DABBLE_LIMIT) ? (digit_q + DABBLE_OFFSET) : digit_q;
  assign carry_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ----- sv/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts a binary number to its decimal ascii text. Each input transaction
// carries a value (low VALUE_WIDTH bits used) and a signed flag; the block
// returns one output transaction per character, most significant first, with
// a leading '-' for a negative signed value and tlast on the final digit.
// Zero gives a single '0'; there are never leading zeros, and the most
// negative signed value prints correctly. The conversion runs on a row of
// bcd digit cells (shift-and-add-3): the magnitude is shifted into the row
// one bit per cycle. Each item is accepted, then its VALUE_WIDTH bits are
// shifted in, then the leading zero positions are dropped one per cycle, and
// then the characters are sent one per cycle while the output side does not
// stall. One item is in work at a time; its last character may wait in the
// output register while the next item is accepted.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64  // 8 to 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_BITS-1:0] s_axis_tdata,   // [63:0] value
  input  logic                  s_axis_tuser,   // [0] is_signed
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic                  m_axis_tlast    // last
);

  // decimal digits needed for the largest unsigned value: floor(w*log10(2))+1
  localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned LEFT_W     = $clog2(NUM_DIGITS + 1);
  localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH);

  state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;      // magnitude being shifted into the cells
  logic [CNT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [LEFT_W-1:0]      left_q, left_d;    // digit positions still in the row
  logic                   neg_q, neg_d;      // minus sign still to send

  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   emit_load;
  logic                   skip_zero;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;

  cell_ctrl_t             cell_ctrl;
  logic [DIGIT_W-1:0]     digit_w [NUM_DIGITS];
  logic                   carry_w [NUM_DIGITS];
  logic [DIGIT_W-1:0]     top_digit;

  // ---------------------------------------------------------------------------
  // input side: magnitude of the number
  // ---------------------------------------------------------------------------
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_neg    = s_axis_tuser && in_value[VALUE_WIDTH-1];
  // two's complement negate; the most negative value maps onto itself, which
  // read as unsigned is exactly its magnitude
  assign in_mag    = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

  // ---------------------------------------------------------------------------
  // row of bcd digit cells, cell 0 least significant
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;

    if (i == 0) begin : g_first
      assign bit_in   = bin_q[VALUE_WIDTH-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry_w[i-1];
      assign digit_in = digit_w[i-1];
    end

    b2da_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .carry_o (carry_w[i]),
      .digit_o (digit_w[i])
    );
  end

  assign top_digit = digit_w[NUM_DIGITS-1];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_q || m_axis_tready;
  // drop a leading zero, but always keep the ones digit
  assign skip_zero = (top_digit == '0) && (left_q > LEFT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_q == '0) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!skip_zero) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && !neg_q && (left_q == LEFT_W'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    emit_load        = 1'b0;
    cell_ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready   = 1'b1;
        cell_ctrl.clear = s_axis_tvalid;
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
      end
      ST_SKIP: begin
        cell_ctrl.shift = skip_zero;
      end
      ST_EMIT: begin
        emit_load       = out_free;
        cell_ctrl.shift = out_free && !neg_q;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    bin_d     = bin_q;
    bit_cnt_d = bit_cnt_q;
    left_d    = left_q;
    neg_d     = neg_q;
    if (in_accept) begin
      bin_d     = in_mag;
      bit_cnt_d = CNT_W'(VALUE_WIDTH - 1);
      left_d    = LEFT_W'(NUM_DIGITS);
      neg_d     = in_neg;
    end else begin
      if (cell_ctrl.dabble) begin
        bin_d     = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - CNT_W'(1);
      end
      if (cell_ctrl.shift) begin
        left_d = left_q - LEFT_W'(1);
      end
      if (emit_load && neg_q) begin
        neg_d = 1'b0;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (emit_load) begin
      out_valid_d = 1'b1;
      out_char_d  = neg_q ? CHAR_MINUS : (CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit});
      out_last_d  = !neg_q && (left_q == LEFT_W'(1));
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      left_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      left_q      <= left_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8-CHAR_W){1'b0}}, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // only the minus sign or a decimal digit ever leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q == CHAR_MINUS) ||
                    ((out_char_q >= CHAR_ZERO) && (out_char_q <= CHAR_ZERO + 6'd9)))
    else $error("output character is neither a digit nor a minus sign");

  // the minus sign never closes a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_char_q == CHAR_MINUS)) |-> !out_last_q)
    else $error("minus sign marked as last character");

  // the digit row never runs empty while characters are still being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SKIP) || (state_q == ST_EMIT)) |-> (left_q != '0))
    else $error("no digit left in the cell row during emission");

  // an accepted transaction always starts a conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_CONV))
    else $error("accepted transaction did not start conversion");

  // a new conversion never starts with the minus sign of the old one left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !neg_q)
    else $error("transaction accepted with a pending minus sign");

  // the most significant cell never overflows while bits are shifted in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.dabble |-> !carry_w[NUM_DIGITS-1])
    else $error("digit row overflow during conversion");

endmodule
